[design/pfa_pkg.sv]
// Shared constants, codes and types of the per-CPU page allocator.
`default_nettype none
package pfa_pkg;

    localparam int NUM_CPUS   = 8;
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W = 32;
    localparam int IDX_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int LINK_W = IDX_W + 1;

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] REGION_END_RST   = 32'h8800_0000;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_BADADDR = 2'd2
    } t_status;

    typedef enum logic {
        REG_REGION_START = 1'b0,
        REG_REGION_END   = 1'b1
    } t_reg;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

    // Result of the free-address check.
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } t_chk;

    // One link entry: more is set when link points at a further page.
    typedef struct packed {
        logic             more;
        logic [IDX_W-1:0] link;
    } t_link;

endpackage
`default_nettype wire

[design/pfa_link_ram.sv]
// Synchronous single-port-write, single-port-read link memory.
`default_nettype none
module pfa_link_ram #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 16,
    parameter int AW    = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[design/pfa_check.sv]
// Free-address check and page number computation.
`default_nettype none
module pfa_check (
    input  wire logic [pfa_pkg::ADDR_W-1:0] i_region_start,
    input  wire logic [pfa_pkg::ADDR_W-1:0] i_region_end,
    input  wire logic [pfa_pkg::ADDR_W-1:0] i_addr,
    output pfa_pkg::t_chk                   o_chk
);
    import pfa_pkg::*;

    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] page_no;
    logic              aligned;
    logic              in_range;
    logic              idx_ok;

    always_comb begin
        base     = i_region_start & ~PAGE_MASK;
        aligned  = (i_addr & PAGE_MASK) == '0;
        in_range = (i_addr >= i_region_start) && (i_addr < i_region_end);
        // Only meaningful when in_range holds, since base never exceeds the address then.
        diff     = i_addr - base;
        page_no  = diff >> PAGE_SHIFT;
        idx_ok   = page_no < ADDR_W'(NUM_PAGES);
        o_chk.ok  = aligned && in_range && idx_ok;
        o_chk.idx = page_no[IDX_W-1:0];
    end

endmodule
`default_nettype wire

[design/per_cpu_page_free_list_allocator_core.sv]
// Top level of the per-CPU page allocator: list heads, sequencer and result register.
//
//  Channel | Direction | Handshake                 | Payload
//  input   | in        | i_in_valid / o_in_stall   | i_cmd, i_cpu_id, i_page_addr_in
//  output  | out       | o_out_valid / i_out_stall | o_page_addr_out, o_status
//  config  | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A free, and an allocate that finds every list empty, load the result register
// directly. An allocate that pops first reads the link of the popped page from
// the synchronous link memory before the list head can be updated.
// Synchronous reset empties every list; the link memory needs no clearing.
// A result waits in the output register while i_out_stall is high; a new beat is
// taken when idle and that register is free or being emptied in the same cycle.
`default_nettype none
module per_cpu_page_free_list_allocator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_cmd,
    input  wire logic [2:0]                    i_cpu_id,
    input  wire logic [pfa_pkg::ADDR_W-1:0]    i_page_addr_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [pfa_pkg::ADDR_W-1:0]    o_page_addr_out,
    output logic      [1:0]                    o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [pfa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import pfa_pkg::*;

    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_region_start;
    logic [ADDR_W-1:0] r_region_end;

    logic [IDX_W-1:0] r_head [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_ne;

    logic [CPU_W-1:0] r_pop_cpu;
    logic [IDX_W-1:0] r_pop_idx;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;

    t_chk             chk;
    t_link            rd_link;
    logic [LINK_W-1:0] rd_raw;

    logic             in_fire;
    logic             out_free;
    logic             cpu_ok;
    logic [CPU_W-1:0] own_cpu;
    logic             any_ne;
    logic [CPU_W-1:0] sel_cpu;
    logic [ADDR_W-1:0] base;

    logic             ram_we;
    logic             ram_re;
    logic             push_en;
    logic             pop_done;
    logic             out_load;
    logic [ADDR_W-1:0] out_addr;
    t_status          out_status;

    pfa_check u_check (
        .i_region_start (r_region_start),
        .i_region_end   (r_region_end),
        .i_addr         (i_page_addr_in),
        .o_chk          (chk)
    );

    pfa_link_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (LINK_W),
        .AW    (IDX_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (chk.idx),
        .i_wdata ({r_ne[own_cpu], r_head[own_cpu]}),
        .i_re    (ram_re),
        .i_raddr (r_head[sel_cpu]),
        .o_rdata (rd_raw)
    );

    assign rd_link = t_link'(rd_raw);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign base = r_region_start & ~PAGE_MASK;

    // Own list first; otherwise the lowest-numbered non-empty list. When the
    // own list is empty it cannot be the lowest non-empty one.
    always_comb begin
        cpu_ok  = 32'(i_cpu_id) < NUM_CPUS;
        own_cpu = CPU_W'(i_cpu_id);
        any_ne  = |r_ne;
        sel_cpu = '0;
        for (int c = NUM_CPUS - 1; c >= 0; c--) begin
            if (r_ne[c]) begin
                sel_cpu = CPU_W'(c);
            end
        end
        if (cpu_ok && r_ne[own_cpu]) begin
            sel_cpu = own_cpu;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && t_cmd'(i_cmd) == CMD_ALLOC && any_ne) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output and datapath control.
    always_comb begin
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        push_en    = 1'b0;
        pop_done   = 1'b0;
        out_load   = 1'b0;
        out_addr   = '0;
        out_status = STAT_OK;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (t_cmd'(i_cmd) == CMD_FREE) begin
                        out_load = 1'b1;
                        if (chk.ok && cpu_ok) begin
                            ram_we  = 1'b1;
                            push_en = 1'b1;
                        end else begin
                            out_status = STAT_BADADDR;
                        end
                    end else if (any_ne) begin
                        ram_re = 1'b1;
                    end else begin
                        out_load   = 1'b1;
                        out_status = STAT_EMPTY;
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    pop_done = 1'b1;
                    out_load = 1'b1;
                    out_addr = base + (ADDR_W'(r_pop_idx) << PAGE_SHIFT);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_region_start <= REGION_START_RST;
            r_region_end   <= REGION_END_RST;
            r_ne           <= '0;
            r_out_valid    <= 1'b0;
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_head[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_index))
                    REG_REGION_START: r_region_start <= i_cfg_data;
                    REG_REGION_END:   r_region_end   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push_en) begin
                r_head[own_cpu] <= chk.idx;
                r_ne[own_cpu]   <= 1'b1;
            end
            if (pop_done) begin
                if (rd_link.more) begin
                    r_head[r_pop_cpu] <= rd_link.link;
                end else begin
                    r_head[r_pop_cpu] <= '0;
                    r_ne[r_pop_cpu]   <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_pop_cpu <= sel_cpu;
            r_pop_idx <= r_head[sel_cpu];
        end
        if (out_load) begin
            r_out_addr   <= out_addr;
            r_out_status <= out_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_page_addr_out = r_out_addr;
    assign o_status        = r_out_status;

    a_pop_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> r_ne[r_pop_cpu])
        else $error("pop in progress on an empty list");

    a_alloc_enters_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_cmd == CMD_ALLOC && any_ne) |=> (r_state == S_POP))
        else $error("allocate with a non-empty list did not start a pop");

    a_free_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_cmd == CMD_FREE) |=> (o_out_valid && o_page_addr_out == '0))
        else $error("free beat gave no result in the next cycle");

    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_OK) |-> (o_page_addr_out == '0))
        else $error("error result carries a nonzero address");

endmodule
`default_nettype wire
